// ===== rtl/core/tdics_pkg.sv =====
// Package for the 2-D inverse-CDF sampler: table geometry, derived widths, FSM states.
`default_nettype none

package tdics_pkg;

    localparam int ENERGY_BINS = 64;
    localparam int ANGLE_BINS  = 32;

    localparam int E_W    = $clog2(ENERGY_BINS);   // column index width
    localparam int A_W    = $clog2(ANGLE_BINS);    // row index width
    localparam int W_AW   = A_W + E_W;             // weight memory address width
    localparam int WGT_W  = 32;                    // bin weight width
    localparam int U_W    = 32;                    // uniform fraction width
    localparam int ROW_W  = WGT_W + E_W;           // row sum width
    localparam int TOT_W  = ROW_W + A_W;           // grand total width
    localparam int MUL_W  = 2 * U_W;               // multiplier product width

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_MA0,
        S_MA1,
        S_MA2,
        S_RSCAN,
        S_ME0,
        S_ME1,
        S_ME2,
        S_CSCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/two_d_inverse_cdf_sampler.sv =====
// Top level of the 2-D inverse-CDF sampler: weight and row-sum memories, scan FSM, output register.
`default_nettype none
// Usage
//   Input channel (i_in_valid / o_in_stall): one transfer per item. i_kind = 0 loads
//   i_weight into bin (i_angle_bin, i_energy_bin) and updates that row sum and the grand
//   total; it gives no result. i_kind = 1 requests one sample using i_u_angle and
//   i_u_energy and gives exactly one result.
//   Output channel (o_out_valid / i_out_stall): one transfer per sample, carrying the
//   picked column, row and the empty flag.
// Operation
//   A load passes through accept, memory read and read-modify-write.
//   A sample first scans rows and then columns, where R (1..32) is the number of rows
//   scanned and C (1..64) the number of columns scanned. R and C come from the row-sum
//   memory and the weight memory, each read one entry per cycle; the two thresholds
//   are each formed on the one shared 32x32 multiplier. An empty table skips both scans.
// Reset
//   After i_rst_n a clearing pass writes zero to all 2048 weight entries and all row
//   sums, one entry per cycle, with o_in_stall held high during the pass.
// Stall
//   A finished result waits in the output register; a new item is accepted meanwhile.
//   A following sample holds in its last state until the register is free.
module two_d_inverse_cdf_sampler
    import tdics_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic [E_W-1:0]     i_energy_bin,
    input  wire logic [A_W-1:0]     i_angle_bin,
    input  wire logic [WGT_W-1:0]   i_weight,
    input  wire logic [U_W-1:0]     i_u_angle,
    input  wire logic [U_W-1:0]     i_u_energy,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [E_W-1:0]          o_picked_energy,
    output logic [A_W-1:0]          o_picked_angle,
    output logic                    o_empty_flag
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [W_AW-1:0]    r_clr;

    // captured item
    logic               r_kind;
    logic [E_W-1:0]     r_energy_bin;
    logic [A_W-1:0]     r_angle_bin;
    logic [WGT_W-1:0]   r_weight;
    logic [U_W-1:0]     r_u_angle;
    logic [U_W-1:0]     r_u_energy;

    // scan datapath
    logic [TOT_W-1:0]   r_total;     // grand total, architectural state
    logic [TOT_W-1:0]   r_cum;       // running cumulative weight
    logic [TOT_W-1:0]   r_thr;       // floor(u * sum / 2^32)
    logic [ROW_W-1:0]   r_rsum;      // sum of the picked row
    logic [A_W-1:0]     r_row;
    logic [E_W-1:0]     r_col;
    logic               r_flag;
    logic [MUL_W-1:0]   r_mul;
    logic [U_W-1:0]     r_mhi;       // upper half of the low partial product

    // output register
    logic               r_out_valid;
    logic [E_W-1:0]     r_out_energy;
    logic [A_W-1:0]     r_out_angle;
    logic               r_out_flag;

    // ------------------------------------------------------------------
    // Memories: weight table and row sums, registered read
    // ------------------------------------------------------------------
    logic [WGT_W-1:0]   weight_mem [2**W_AW];
    logic [ROW_W-1:0]   rsum_mem   [2**A_W];

    logic               w_we;
    logic [W_AW-1:0]    w_wa;
    logic [WGT_W-1:0]   w_wd;
    logic [W_AW-1:0]    w_ra;
    logic [WGT_W-1:0]   r_w_rd;

    logic               rs_we;
    logic [A_W-1:0]     rs_wa;
    logic [ROW_W-1:0]   rs_wd;
    logic [A_W-1:0]     rs_ra;
    logic [ROW_W-1:0]   r_rs_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            weight_mem[w_wa] <= w_wd;
        end
        r_w_rd <= weight_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rsum_mem[rs_wa] <= rs_wd;
        end
        r_rs_rd <= rsum_mem[rs_ra];
    end

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic               in_xfer;
    logic               out_xfer;
    logic               out_load;
    logic               ld_ok;
    logic               clr_in_rows;
    logic [TOT_W-1:0]   cum_row_n;
    logic [TOT_W-1:0]   cum_col_n;
    logic               row_hit;
    logic               col_hit;
    logic               row_last;
    logic               col_last;
    logic [U_W-1:0]     mul_a;
    logic [U_W-1:0]     mul_b;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign ld_ok       = (32'(r_energy_bin) < ENERGY_BINS) && (32'(r_angle_bin) < ANGLE_BINS);
    assign clr_in_rows = (r_clr[W_AW-1:A_W] == '0);

    // a row or column is chosen when thr < cumulative weight, which is
    // u * sum < cum * 2^32 with the low product bits dropped exactly
    assign cum_row_n = r_cum + TOT_W'(r_rs_rd);
    assign cum_col_n = r_cum + TOT_W'(r_w_rd);
    assign row_hit   = r_thr < cum_row_n;
    assign col_hit   = r_thr < cum_col_n;
    assign row_last  = (r_row == A_W'(ANGLE_BINS - 1));
    assign col_last  = (r_col == E_W'(ENERGY_BINS - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_kind ? S_MA0 : S_LD_RD;
                end
            end
            S_LD_RD: n_state = S_LD_WR;
            S_LD_WR: n_state = S_IDLE;
            S_MA0: begin
                n_state = (r_total == '0) ? S_DONE : S_MA1;
            end
            S_MA1:   n_state = S_MA2;
            S_MA2:   n_state = S_RSCAN;
            S_RSCAN: begin
                if (row_hit || row_last) begin
                    n_state = S_ME0;
                end
            end
            S_ME0: begin
                n_state = (r_rsum == '0) ? S_DONE : S_ME1;
            end
            S_ME1:   n_state = S_ME2;
            S_ME2:   n_state = S_CSCAN;
            S_CSCAN: begin
                if (col_hit || col_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: memory ports, multiplier operands, input stall
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        w_we  = 1'b0;
        w_wa  = {r_angle_bin, r_energy_bin};
        w_wd  = r_weight;
        w_ra  = {r_angle_bin, r_energy_bin};
        rs_we = 1'b0;
        rs_wa = r_angle_bin;
        rs_wd = r_rs_rd - ROW_W'(r_w_rd) + ROW_W'(r_weight);
        rs_ra = r_angle_bin;
        mul_a = r_u_angle;
        mul_b = '0;
        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                rs_we = clr_in_rows;
                rs_wa = r_clr[A_W-1:0];
                rs_wd = '0;
            end
            S_IDLE:  o_in_stall = 1'b0;
            S_LD_WR: begin
                w_we  = ld_ok;
                rs_we = ld_ok;
            end
            S_MA0:   mul_b = r_total[U_W-1:0];
            S_MA1:   mul_b = U_W'(r_total[TOT_W-1:U_W]);
            S_MA2:   rs_ra = '0;
            S_RSCAN: rs_ra = r_row + A_W'(1);
            S_ME0: begin
                mul_a = r_u_energy;
                mul_b = r_rsum[U_W-1:0];
            end
            S_ME1: begin
                mul_a = r_u_energy;
                mul_b = U_W'(r_rsum[ROW_W-1:U_W]);
            end
            S_ME2:   w_ra = {r_row, E_W'(0)};
            S_CSCAN: w_ra = {r_row, r_col + E_W'(1)};
            default: o_in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + W_AW'(1);
            end
            // apply the load correction to the grand total
            if (r_state == S_LD_WR && ld_ok) begin
                r_total <= r_total - TOT_W'(r_w_rd) + TOT_W'(r_weight);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_mul <= MUL_W'(mul_a) * MUL_W'(mul_b);

        if (in_xfer) begin
            r_kind       <= i_kind;
            r_energy_bin <= i_energy_bin;
            r_angle_bin  <= i_angle_bin;
            r_weight     <= i_weight;
            r_u_angle    <= i_u_angle;
            r_u_energy   <= i_u_energy;
            r_row        <= '0;
            r_col        <= '0;
            r_flag       <= 1'b0;
        end

        case (r_state)
            S_MA0: begin
                if (r_total == '0) begin
                    r_flag <= 1'b1;
                end
            end
            S_MA1, S_ME1: r_mhi <= r_mul[MUL_W-1:U_W];
            S_MA2, S_ME2: begin
                // high word of u*sum = high partial + carry-in from low partial
                r_thr <= r_mul[TOT_W-1:0] + TOT_W'(r_mhi);
                r_cum <= '0;
            end
            S_RSCAN: begin
                if (row_hit || row_last) begin
                    r_rsum <= r_rs_rd;
                end else begin
                    r_cum <= cum_row_n;
                    r_row <= r_row + A_W'(1);
                end
            end
            S_ME0: begin
                if (r_rsum == '0) begin
                    r_flag <= 1'b1;
                end
            end
            S_CSCAN: begin
                if (!(col_hit || col_last)) begin
                    r_cum <= cum_col_n;
                    r_col <= r_col + E_W'(1);
                end
            end
            default: r_mhi <= r_mhi;
        endcase

        if (out_load) begin
            r_out_energy <= r_col;
            r_out_angle  <= r_row;
            r_out_flag   <= r_flag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_picked_energy = r_out_energy;
    assign o_picked_angle  = r_out_angle;
    assign o_empty_flag    = r_out_flag;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while held");

    a_thr_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSCAN) |-> (r_thr < r_total))
        else $error("row threshold not below grand total");

    a_cum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSCAN) |-> (r_cum <= r_total))
        else $error("row scan ran past grand total");

    a_empty_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flag) |-> (r_out_energy == '0))
        else $error("empty result with nonzero column");

    a_sample_only_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> r_kind)
        else $error("load item produced a result");

endmodule

`default_nettype wire
